@@ sv/sst_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sst_pkg: shared types, constants and helpers of the source tokenizer
// Token kinds, character codes, saturation limit and per-byte run record.
// ---------------------------------------------------------------------------
package sst_pkg;

	// Text size limit; offsets and lengths saturate one below it, at most 16 bits
	localparam int unsigned MAX_TEXT_BYTES = 65536;
	localparam int unsigned LIMIT_INT =
		((MAX_TEXT_BYTES - 1) > 65535) ? 65535 : (MAX_TEXT_BYTES - 1);
	localparam logic [15:0] OFFSET_LIMIT = 16'(LIMIT_INT);

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Tokens one byte can produce: closed token, single/closed token, end token
	localparam int SLOTS = 3;

	// Character codes
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// Keywords as packed leading characters, first char in low byte
	localparam logic [31:0] KW_IF   = 32'h0000_6669;
	localparam logic [31:0] KW_ELSE = 32'h6573_6C65;

	typedef enum logic [2:0] {
		TK_IDENT    = 3'd0,
		TK_KEYWORD  = 3'd1,
		TK_NUMBER   = 3'd2,
		TK_OPERATOR = 3'd3,
		TK_PUNCT    = 3'd4,
		TK_END      = 3'd5,
		TK_UNKNOWN  = 3'd6
	} tok_kind_t;

	typedef enum logic [1:0] {
		PEND_NONE   = 2'd0,
		PEND_IDENT  = 2'd1,
		PEND_NUMBER = 2'd2
	} pend_kind_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [7:0]  ch;
	} token_t;

	// All tokens caused by one byte, in output order
	typedef struct packed {
		logic [SLOTS-1:0]   valid;
		token_t [SLOTS-1:0] slot;
	} run_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic push;
		logic pop;
	} queue_status_t;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v >= OFFSET_LIMIT) ? OFFSET_LIMIT : 16'(v + 16'd1);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c inside {8'h20, [8'h09:8'h0D]};
	endfunction

	// Build the token for an open identifier or number being closed
	function automatic token_t close_token(input pend_kind_t  pk,
	                                       input logic [15:0] start,
	                                       input logic [15:0] len,
	                                       input logic [31:0] lead);
		token_t t;
		t.kind = TK_IDENT;
		if (pk == PEND_NUMBER) begin
			t.kind = TK_NUMBER;
		end else if ((len == 16'd2 && lead == KW_IF) ||
		             (len == 16'd4 && lead == KW_ELSE)) begin
			t.kind = TK_KEYWORD;
		end
		t.start  = start;
		t.length = len;
		t.ch     = (len == 16'd1) ? lead[7:0] : 8'd0;
		return t;
	endfunction

endpackage
`default_nettype wire

@@ sv/sst_front.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sst_front: byte classifier and token state
// Takes one byte per cycle while the run queue is not full, tracks the open
// token and builds the run of tokens that byte closes or emits.
// ---------------------------------------------------------------------------
module sst_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [7:0]    text_byte,
	input  wire logic          final_byte,
	input  wire logic          q_full,
	output logic               run_push,
	output sst_pkg::run_t      run
);
	import sst_pkg::*;

	pend_kind_t  pkind_q;
	logic [15:0] pstart_q;
	logic [15:0] plen_q;
	logic [31:0] lead_q;
	logic [15:0] offset_q;

	pend_kind_t  pk2;
	logic [15:0] ps2;
	logic [15:0] pl2;
	logic [31:0] ld2;
	logic [15:0] next_off;
	logic        letter;
	logic        digit;
	logic        extend;
	logic        accept;
	tok_kind_t   single_kind;

	// Single-character token class
	always_comb begin
		case (text_byte) inside
			CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH:      single_kind = TK_OPERATOR;
			CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE: single_kind = TK_PUNCT;
			default:                                   single_kind = TK_UNKNOWN;
		endcase
	end

	// Token state update and run assembly
	always_comb begin
		letter   = is_letter(text_byte);
		digit    = is_digit(text_byte);
		extend   = (pkind_q == PEND_IDENT && (letter || digit)) ||
		           (pkind_q == PEND_NUMBER && digit);
		next_off = sat_inc(offset_q);
		pk2      = pkind_q;
		ps2      = pstart_q;
		pl2      = plen_q;
		ld2      = lead_q;
		run      = '0;

		if (extend) begin
			// only the first four chars are kept for keyword matching
			if (pkind_q == PEND_IDENT && plen_q[15:2] == 14'd0) begin
				ld2 = lead_q | ({24'd0, text_byte} << {plen_q[1:0], 3'b000});
			end
			pl2 = sat_inc(plen_q);
		end else begin
			if (pkind_q != PEND_NONE) begin
				run.valid[0] = 1'b1;
				run.slot[0]  = close_token(pkind_q, pstart_q, plen_q, lead_q);
			end
			pk2 = PEND_NONE;
			pl2 = 16'd0;
			ld2 = 32'd0;
			if (is_space(text_byte)) begin
				// separator only
			end else if (letter || digit) begin
				pk2 = letter ? PEND_IDENT : PEND_NUMBER;
				ps2 = offset_q;
				pl2 = 16'd1;
				ld2 = {24'd0, text_byte};
			end else begin
				run.valid[1]       = 1'b1;
				run.slot[1].kind   = single_kind;
				run.slot[1].start  = offset_q;
				run.slot[1].length = 16'd1;
				run.slot[1].ch     = text_byte;
			end
		end

		// last byte: flush the open token, then the end token
		if (final_byte) begin
			if (pk2 != PEND_NONE) begin
				run.valid[1] = 1'b1;
				run.slot[1]  = close_token(pk2, ps2, pl2, ld2);
			end
			run.valid[2]       = 1'b1;
			run.slot[2].kind   = TK_END;
			run.slot[2].start  = next_off;
			run.slot[2].length = 16'd0;
			run.slot[2].ch     = 8'd0;
		end
	end

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign run_push = accept && (|run.valid);

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkind_q  <= PEND_NONE;
			pstart_q <= 16'd0;
			plen_q   <= 16'd0;
			lead_q   <= 32'd0;
			offset_q <= 16'd0;
		end else if (accept) begin
			if (final_byte) begin
				pkind_q  <= PEND_NONE;
				pstart_q <= 16'd0;
				plen_q   <= 16'd0;
				lead_q   <= 32'd0;
				offset_q <= 16'd0;
			end else begin
				pkind_q  <= pk2;
				pstart_q <= ps2;
				plen_q   <= pl2;
				lead_q   <= ld2;
				offset_q <= next_off;
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/sst_queue.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sst_queue: short run queue between front and back
// Holds per-byte token runs so front and back stall independently.
// ---------------------------------------------------------------------------
module sst_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire sst_pkg::run_t        wr_run,
	input  wire logic                 pop,
	output sst_pkg::run_t             head,
	output sst_pkg::queue_status_t    status
);
	import sst_pkg::*;

	run_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign status.push  = push;
	assign status.pop   = pop;
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = entry_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_run;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				count_q <= QCNT_W'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= QCNT_W'(count_q - 1'b1);
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/sst_back.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sst_back: token emitter
// Walks the valid slots of the head run into the output register, one token
// per cycle unless out_stall holds it; pops the run after its last token.
// ---------------------------------------------------------------------------
module sst_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sst_pkg::run_t   head,
	input  wire logic            q_empty,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output sst_pkg::token_t      out_token,
	output logic                 out_last
);
	import sst_pkg::*;

	logic [SLOTS-1:0] done_q;
	logic             out_valid_q;
	token_t           token_q;
	logic             last_q;

	logic [SLOTS-1:0] pending;
	logic [SLOTS-1:0] pick;
	logic [1:0]       sel;
	logic             last;
	logic             load;

	// Lowest slot not yet sent
	always_comb begin
		pending = head.valid & ~done_q;
		if (pending[0]) begin
			sel = 2'd0;
		end else if (pending[1]) begin
			sel = 2'd1;
		end else begin
			sel = 2'd2;
		end
		pick = SLOTS'(1) << sel;
		last = ((pending & ~pick) == '0);
		load = !q_empty && (!out_valid_q || !out_stall);
	end

	assign q_pop     = load && last;
	assign out_valid = out_valid_q;
	assign out_token = token_q;
	assign out_last  = last_q;

	// Output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			token_q <= head.slot[sel];
			last_q  <= last;
		end
	end

	// Output valid and slot progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			done_q      <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			done_q      <= last ? '0 : (done_q | pick);
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

@@ sv/simple_source_tokenizer_unit.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// simple_source_tokenizer_unit: streaming source tokenizer
// Turns a byte stream into kind/offset/length tokens.
// ---------------------------------------------------------------------------
// Accepts one source byte per cycle while the four-entry run queue has room,
// and delivers one token per cycle from a registered output while out_stall
// is low. A byte causes zero to three tokens (closed token, one-character
// token, end token), which the output side delivers one at a time, so
// sustained input rate is one byte per cycle as long as the average token
// count per byte stays at or below one, with the queue absorbing bursts.
// Offsets and lengths saturate at 65535; the byte flagged as last closes the
// open token, is followed by an end token, and the next byte starts a new
// text at offset 0. An accepted byte's run is written into the queue, and
// its first token then passes through the output register.
module simple_source_tokenizer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  text_byte,
	input  wire logic        final_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       token_kind,
	output logic [15:0]      token_start,
	output logic [15:0]      token_length,
	output logic [7:0]       single_char,
	output logic             last_of_run
);
	import sst_pkg::*;

	run_t          wr_run;
	run_t          head;
	logic          run_push;
	logic          q_pop;
	queue_status_t q_stat;
	token_t        out_token;

	sst_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.q_full     (q_stat.full),
		.run_push   (run_push),
		.run        (wr_run)
	);

	sst_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (run_push),
		.wr_run (wr_run),
		.pop    (q_pop),
		.head   (head),
		.status (q_stat)
	);

	sst_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_stat.empty),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_token (out_token),
		.out_last  (last_of_run)
	);

	// Output fields
	assign token_kind   = out_token.kind;
	assign token_start  = out_token.start;
	assign token_length = out_token.length;
	assign single_char  = out_token.ch;

`ifndef SYNTHESIS
	// front never pushes into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.push && q_stat.full))
		else $error("run pushed into full queue");

	// back never pops an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.pop |-> !q_stat.empty)
		else $error("run popped from empty queue");

	// end token closes its run and carries no characters
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && token_kind == TK_END) |->
		(last_of_run && token_length == 16'd0 && single_char == 8'd0))
		else $error("malformed end token");
`endif

endmodule
`default_nettype wire

@@ tb/sv/simple_source_tokenizer_unit_test.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// simple_source_tokenizer_unit_test: self-checking bench for the tokenizer
// A short scripted text under the first idling mix, then random texts under
// all three idling mixes, are sent through the tokenizer. A model in the
// bench predicts each token, or a typed script row gives it. A monitor checks
// each delivered token in order, and a watchdog catches a hung handshake.
module simple_source_tokenizer_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sst_pkg::*;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam int STALL_LIMIT      = 3000;
	localparam int SCRIPT_ROWS      = 25;
	localparam int RANDOM_PER_PHASE = 130;
	localparam int PRINT_CAP        = 50;

	localparam logic [7:0] OPERATOR_CHARS [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
	localparam logic [7:0] PUNCT_CHARS [4]    = '{CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE};

	typedef enum logic [1:0] {
		CC_BLANK,
		CC_ALPHA,
		CC_DIGIT,
		CC_OTHER
	} char_class_t;

	// One expected token
	typedef struct packed {
		tok_kind_t   kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [7:0]  ch;
		logic        ends_run;
	} tok_exp_t;

	// One scripted byte; tok is used only where typed is set
	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
		logic       typed;
		tok_exp_t   tok;
	} script_row_t;

	localparam tok_exp_t NO_TOKEN = '0;

	// Scripted text: extremes, every token kind, keywords and near misses,
	// final byte on an open token and on whitespace, restart at offset 0
	localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
		'{CH_PLUS,   1'b0, 1'b1, '{TK_OPERATOR, 16'd0, 16'd1, CH_PLUS, 1'b1}},
		'{8'h00,     1'b0, 1'b1, '{TK_UNKNOWN,  16'd1, 16'd1, 8'h00, 1'b1}},
		'{8'hFF,     1'b0, 1'b1, '{TK_UNKNOWN,  16'd2, 16'd1, 8'hFF, 1'b1}},
		'{CH_LPAREN, 1'b0, 1'b1, '{TK_PUNCT,    16'd3, 16'd1, CH_LPAREN, 1'b1}},
		'{"i",       1'b0, 1'b0, NO_TOKEN},
		'{"f",       1'b0, 1'b0, NO_TOKEN},
		'{" ",       1'b0, 1'b0, NO_TOKEN},
		'{"e",       1'b0, 1'b0, NO_TOKEN},
		'{"l",       1'b0, 1'b0, NO_TOKEN},
		'{"s",       1'b0, 1'b0, NO_TOKEN},
		'{"e",       1'b0, 1'b0, NO_TOKEN},
		'{CH_RBRACE, 1'b0, 1'b0, NO_TOKEN},
		'{"0",       1'b0, 1'b0, NO_TOKEN},
		'{"9",       1'b0, 1'b0, NO_TOKEN},
		'{CH_STAR,   1'b0, 1'b0, NO_TOKEN},
		'{"x",       1'b1, 1'b0, NO_TOKEN},
		'{" ",       1'b1, 1'b1, '{TK_END, 16'd1, 16'd0, 8'h00, 1'b1}},
		'{"i",       1'b0, 1'b0, NO_TOKEN},
		'{"f",       1'b0, 1'b0, NO_TOKEN},
		'{"x",       1'b0, 1'b0, NO_TOKEN},
		'{"7",       1'b0, 1'b0, NO_TOKEN},
		'{"\t",      1'b0, 1'b0, NO_TOKEN},
		'{"e",       1'b0, 1'b0, NO_TOKEN},
		'{"l",       1'b0, 1'b0, NO_TOKEN},
		'{"s",       1'b1, 1'b0, NO_TOKEN}
	};

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic [7:0]  text_byte    = 8'h00;
	logic        final_byte   = 1'b0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic [2:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic [7:0]  single_char;
	logic        last_of_run;

	// Tokenizer model state
	pend_kind_t  open_kind   = PEND_NONE;
	logic [15:0] open_start  = '0;
	logic [15:0] open_len    = '0;
	logic [31:0] open_lead   = '0;
	logic [15:0] text_offset = '0;

	tok_exp_t    byte_tokens[$];
	tok_exp_t    expected_tokens[$];

	int          send_idle_pct  = 0;
	int          recv_idle_pct  = 0;
	int          mismatch_count = 0;
	int          tokens_checked = 0;
	int          bytes_sent     = 0;
	int          texts_sent     = 0;
	int          quiet_cycles   = 0;

	simple_source_tokenizer_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.final_byte  (final_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.token_kind  (token_kind),
		.token_start (token_start),
		.token_length(token_length),
		.single_char (single_char),
		.last_of_run (last_of_run)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Tokenizer model
	// ---------------------------------------------------------------------
	function automatic logic [15:0] bump(input logic [15:0] v);
		return (v < OFFSET_LIMIT) ? v + 16'd1 : OFFSET_LIMIT;
	endfunction

	function automatic char_class_t class_of(input logic [7:0] c);
		if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return CC_BLANK;
		if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) return CC_ALPHA;
		if (c >= "0" && c <= "9") return CC_DIGIT;
		return CC_OTHER;
	endfunction

	function automatic void add_token(input tok_kind_t kind, input logic [15:0] start,
	                                  input logic [15:0] length, input logic [7:0] ch);
		tok_exp_t t;
		t.kind     = kind;
		t.start    = start;
		t.length   = length;
		t.ch       = ch;
		t.ends_run = 1'b0;
		byte_tokens = {byte_tokens, t};
	endfunction

	// Emit the open identifier or number, if any, and clear it
	function automatic void close_open_token();
		tok_kind_t kind;
		if (open_kind == PEND_NONE) return;
		kind = (open_kind == PEND_NUMBER) ? TK_NUMBER : TK_IDENT;
		if (open_kind == PEND_IDENT &&
		    ((open_len == 16'd2 && open_lead == KW_IF) ||
		     (open_len == 16'd4 && open_lead == KW_ELSE))) begin
			kind = TK_KEYWORD;
		end
		add_token(kind, open_start, open_len, (open_len == 16'd1) ? open_lead[7:0] : 8'h00);
		open_kind = PEND_NONE;
		open_len  = '0;
		open_lead = '0;
	endfunction

	// Advance the model by one byte; leaves the tokens it causes in byte_tokens
	function automatic void tokenize_byte(input logic [7:0] c, input logic fin);
		logic [15:0] here;
		char_class_t cls;
		tok_kind_t   kind;
		here = text_offset;
		cls  = class_of(c);
		byte_tokens.delete();
		if (open_kind == PEND_IDENT && (cls == CC_ALPHA || cls == CC_DIGIT)) begin
			if (open_len < 16'd4) open_lead[8 * open_len[1:0] +: 8] = c;
			open_len = bump(open_len);
		end else if (open_kind == PEND_NUMBER && cls == CC_DIGIT) begin
			open_len = bump(open_len);
		end else begin
			close_open_token();
			if (cls == CC_ALPHA || cls == CC_DIGIT) begin
				open_kind  = (cls == CC_ALPHA) ? PEND_IDENT : PEND_NUMBER;
				open_start = here;
				open_len   = 16'd1;
				open_lead  = {24'd0, c};
			end else if (cls == CC_OTHER) begin
				case (c)
					CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH:       kind = TK_OPERATOR;
					CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE: kind = TK_PUNCT;
					default:                                    kind = TK_UNKNOWN;
				endcase
				add_token(kind, here, 16'd1, c);
			end
		end
		text_offset = bump(here);
		// Last byte: flush, end token, then a fresh text at offset 0
		if (fin) begin
			close_open_token();
			add_token(TK_END, text_offset, 16'd0, 8'h00);
			open_start  = '0;
			text_offset = '0;
		end
		if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].ends_run = 1'b1;
	endfunction

	// ---------------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------------
	task automatic report_mismatch(input string field, input int got, input int want);
		if (mismatch_count < PRINT_CAP) begin
			$display("%0t: token %0d, %s: got %0h, expected %0h",
			         $realtime, tokens_checked, field, got, want);
		end
		mismatch_count++;
	endtask

	// Compare each delivered token with the oldest prediction
	always @(posedge clk) begin : token_monitor
		tok_exp_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_tokens.size() == 0) begin
				report_mismatch("unexpected token, kind", token_kind, 0);
			end else begin
				e = expected_tokens.pop_front();
				if (token_kind !== e.kind) report_mismatch("token_kind", token_kind, e.kind);
				if (token_start !== e.start) report_mismatch("token_start", token_start, e.start);
				if (token_length !== e.length) begin
					report_mismatch("token_length", token_length, e.length);
				end
				if (single_char !== e.ch) report_mismatch("single_char", single_char, e.ch);
				if (last_of_run !== e.ends_run) begin
					report_mismatch("last_of_run", last_of_run, e.ends_run);
				end
			end
			tokens_checked++;
		end
	end

	// Receiver stalls at random
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Watchdog: too long without any item moving on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout: no handshake for %0d cycles, %0d tokens outstanding",
			         STALL_LIMIT, expected_tokens.size());
			$display("FAIL simple_source_tokenizer_unit");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	// Offer one byte, wait for its acceptance, then book its tokens
	task automatic send_byte(input logic [7:0] c, input logic fin, input logic typed,
	                         input tok_exp_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		text_byte  <= c;
		final_byte <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tokenize_byte(c, fin);
		if (typed) begin
			expected_tokens = {expected_tokens, want};
		end else begin
			expected_tokens = {expected_tokens, byte_tokens};
		end
		bytes_sent++;
	endtask

	// Hold the sender off until every predicted token has come out
	task automatic wait_for_tokens();
		in_valid <= 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_letter();
		return $urandom_range(0, 1) ? 8'($urandom_range("A", "Z")) : 8'($urandom_range("a", "z"));
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'($urandom_range("0", "9"));
	endfunction

	function automatic logic [7:0] rand_blank();
		return ($urandom_range(0, 5) == 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
	endfunction

	// Mostly well-formed token sequences with random content, some noise bytes,
	// and now and then a text left open into the next one
	task automatic send_random_text();
		logic [7:0]  txt[$];
		int unsigned sel;
		int unsigned len;
		logic        keep_open;
		repeat ($urandom_range(1, 6)) begin
			sel = $urandom_range(0, 99);
			if (sel < 25) begin
				len = $urandom_range(1, 6);
				txt = {txt, rand_letter()};
				repeat (len - 1) begin
					txt = {txt, ($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter()};
				end
			end else if (sel < 35) begin
				case ($urandom_range(0, 3))
					0: txt = {txt, "i", "f"};
					1: txt = {txt, "e", "l", "s", "e"};
					2: txt = {txt, "e", "l", "s", "e", rand_digit()};
					default: txt = {txt, "i", "F"};
				endcase
			end else if (sel < 50) begin
				repeat ($urandom_range(1, 5)) txt = {txt, rand_digit()};
			end else if (sel < 62) begin
				txt = {txt, OPERATOR_CHARS[$urandom_range(0, 3)]};
			end else if (sel < 72) begin
				txt = {txt, PUNCT_CHARS[$urandom_range(0, 3)]};
			end else if (sel < 85) begin
				repeat ($urandom_range(1, 3)) txt = {txt, rand_blank()};
			end else begin
				txt = {txt, 8'($urandom_range(0, 255))};
			end
			if ($urandom_range(0, 1)) txt = {txt, rand_blank()};
		end
		keep_open = ($urandom_range(0, 9) == 0);
		foreach (txt[i]) begin
			send_byte(txt[i], (i == txt.size() - 1) && !keep_open, 1'b0, NO_TOKEN);
		end
		texts_sent++;
	endtask

	initial begin : stimulus
		int phase_base;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < 3; phase++) begin
			// Sender-light/receiver-heavy, then reversed, then no idling at all
			send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 57 : 0;
			recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 16 : 0;
			if (phase == 0) begin
				for (int r = 0; r < SCRIPT_ROWS; r++) begin
					send_byte(SCRIPT[r].ch, SCRIPT[r].fin, SCRIPT[r].typed, SCRIPT[r].tok);
				end
			end
			phase_base = bytes_sent;
			while (bytes_sent - phase_base < RANDOM_PER_PHASE) send_random_text();
			wait_for_tokens();
		end

		$display("Sent %0d bytes (%0d random texts) and checked %0d tokens, %0d mismatches.",
		         bytes_sent, texts_sent, tokens_checked, mismatch_count);
		$display("Covered every token kind and keyword under three idling mixes.");
		if (mismatch_count == 0 && expected_tokens.size() == 0) begin
			$display("PASS simple_source_tokenizer_unit");
		end else begin
			$display("FAIL simple_source_tokenizer_unit");
		end
		$finish;
	end

endmodule
`default_nettype wire
